// ----- hdl/rrpd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrpd_pkg
// Shared widths, reset values, register indexes and types of the rate rise
// pulse detector.
// ----------------------------------------------------------------------------
package rrpd_pkg;

    localparam int COUNT_W = 16;
    localparam int PROM_W  = 16;
    localparam int HOLD_W  = 10;
    localparam int TICK_W  = 11;

    localparam logic [TICK_W-1:0] TICK_MAX = 11'd2047;

    localparam logic [PROM_W-1:0] PROM_RST = 16'd10;
    localparam logic [HOLD_W-1:0] HOLD_RST = 10'd50;

    localparam int WINDOW_BEHIND_DEF = 30;
    localparam int LOOKAHEAD_DEF     = 3;
    localparam int MAX_BINS_DEF      = 131072;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROMINENCE = 1'b0,
        CFG_HOLDOFF    = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// ----- hdl/rrpd_if.sv -----
// ----------------------------------------------------------------------------
// rrpd_if
// Valid/ready channels of the rate rise pulse detector: bin input, pulse
// output and configuration write.
// ----------------------------------------------------------------------------
interface rrpd_bin_if;
    logic                         valid;
    logic                         ready;
    logic [rrpd_pkg::COUNT_W-1:0] bin_count;
    logic                         start_run;

    modport source (output valid, output bin_count, output start_run, input ready);
    modport sink   (input valid, input bin_count, input start_run, output ready);
endinterface

interface rrpd_pulse_if #(
    parameter int POS_W = $clog2(rrpd_pkg::MAX_BINS_DEF)
);
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pulse_bin;

    modport source (output valid, output pulse_bin, input ready);
    modport sink   (input valid, input pulse_bin, output ready);
endinterface

interface rrpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rrpd_pkg::CFG_IDX_W-1:0]  index;
    logic [rrpd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rate_rise_pulse_detector.sv -----
// ----------------------------------------------------------------------------
// rate_rise_pulse_detector
// Step trigger on a moving average of histogram bin counts.
// ----------------------------------------------------------------------------
// Usage:
//   i_bin   carries one bin count per word; start_run = 1 clears the history
//           and makes that bin position zero of a new run.
//   o_pulse carries the bin index of each detected rise.
//   i_cfg   writes prominence (index 0), holdoff_bins (index 1); always ready.
//           Write it only while the block is idle; the block does not enforce it.
// Throughput: one bin word per cycle while i_bin.ready is high. The running
//   sums and the hold-off counter update in the same cycle as the compare, so
//   back-to-back bins need no bubbles.
// Output: the bin word that completes a look-ahead window raises its pulse
//   word into the output register, or into the skid entry while it waits.
// Stall: a two-entry output stage (output register plus skid entry) lets
//   bins flow while a pulse waits; i_bin.ready drops only while both
//   entries hold pulses.
// Reset: window cells, sums, position and hold-off clear; prominence is 10
//   and holdoff_bins is 50. No clearing pass is needed.
// Bins past MAX_BINS in one run are taken and dropped until start_run.
// ----------------------------------------------------------------------------
module rate_rise_pulse_detector #(
    parameter int WINDOW_BEHIND = rrpd_pkg::WINDOW_BEHIND_DEF,
    parameter int LOOKAHEAD     = rrpd_pkg::LOOKAHEAD_DEF,
    parameter int MAX_BINS      = rrpd_pkg::MAX_BINS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rrpd_bin_if.sink     i_bin,
    rrpd_cfg_if.sink     i_cfg,
    rrpd_pulse_if.source o_pulse
);

    localparam int POS_W = $clog2(MAX_BINS);
    localparam int DEPTH = WINDOW_BEHIND + LOOKAHEAD;

    logic [rrpd_pkg::PROM_W-1:0] r_prominence;
    logic [rrpd_pkg::HOLD_W-1:0] r_holdoff;

    logic [rrpd_pkg::COUNT_W-1:0] w_tap [DEPTH];
    rrpd_pkg::t_cell_ctl          cell_ctl;
    rrpd_pkg::t_cell_ctl          head_ctl;
    logic                         in_accept;
    logic                         pulse;
    logic [POS_W-1:0]             pulse_bin;

    logic             r_a_valid, n_a_valid;
    logic [POS_W-1:0] r_a_bin,   n_a_bin;
    logic             r_b_valid, n_b_valid;
    logic [POS_W-1:0] r_b_bin,   n_b_bin;
    logic             a_free;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prominence <= rrpd_pkg::PROM_RST;
            r_holdoff    <= rrpd_pkg::HOLD_RST;
        end else if (i_cfg.valid) begin
            unique case (rrpd_pkg::t_cfg_reg'(i_cfg.index))
                rrpd_pkg::CFG_PROMINENCE: r_prominence <= i_cfg.data[rrpd_pkg::PROM_W-1:0];
                rrpd_pkg::CFG_HOLDOFF:    r_holdoff    <= i_cfg.data[rrpd_pkg::HOLD_W-1:0];
            endcase
        end
    end

    assign i_bin.ready = !r_b_valid;
    assign in_accept   = i_bin.valid && !r_b_valid;

    // window of bin counts, newest in cell zero
    assign head_ctl.shift = cell_ctl.shift;
    assign head_ctl.clear = 1'b0;

    generate
        for (genvar k = 0; k < DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                rrpd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (head_ctl),
                    .i_prev  (i_bin.bin_count),
                    .o_count (w_tap[k])
                );
            end else begin : g_body
                rrpd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (cell_ctl),
                    .i_prev  (w_tap[k-1]),
                    .o_count (w_tap[k])
                );
            end
        end
    endgenerate

    rrpd_trigger #(
        .WINDOW_BEHIND (WINDOW_BEHIND),
        .LOOKAHEAD     (LOOKAHEAD),
        .MAX_BINS      (MAX_BINS),
        .POS_W         (POS_W)
    ) u_trigger (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_start      (i_bin.start_run),
        .i_count      (i_bin.bin_count),
        .i_tap_ahead  (w_tap[LOOKAHEAD-1]),
        .i_tap_behind (w_tap[DEPTH-1]),
        .i_prominence (r_prominence),
        .i_holdoff    (r_holdoff),
        .o_cell_ctl   (cell_ctl),
        .o_pulse      (pulse),
        .o_pulse_bin  (pulse_bin)
    );

    // output register with one skid entry behind it
    always_comb begin
        a_free    = !r_a_valid || o_pulse.ready;
        n_a_valid = r_a_valid;
        n_a_bin   = r_a_bin;
        n_b_valid = r_b_valid;
        n_b_bin   = r_b_bin;
        if (a_free) begin
            if (r_b_valid) begin
                n_a_valid = 1'b1;
                n_a_bin   = r_b_bin;
                n_b_valid = pulse;
                n_b_bin   = pulse_bin;
            end else begin
                n_a_valid = pulse;
                n_a_bin   = pulse_bin;
            end
        end else if (pulse) begin
            n_b_valid = 1'b1;
            n_b_bin   = pulse_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
        r_a_bin <= n_a_bin;
        r_b_bin <= n_b_bin;
    end

    assign o_pulse.valid     = r_a_valid;
    assign o_pulse.pulse_bin = r_a_bin;

`ifndef SYNTHESIS
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_a_valid)
        else $error("skid entry full while output register empty");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_b_valid && !o_pulse.ready) |=> (r_a_valid && r_b_valid))
        else $error("pulse word lost while output stalled");

    a_pulse_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pulse |=> r_a_valid)
        else $error("pulse word not held in output stage");
`endif

endmodule

// ----- hdl/rrpd_cell.sv -----
// ----------------------------------------------------------------------------
// rrpd_cell
// One stage of the count window: holds one bin count and passes it on to the
// next stage on every shift.
// ----------------------------------------------------------------------------
module rrpd_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrpd_pkg::t_cell_ctl          i_ctl,
    input  logic [rrpd_pkg::COUNT_W-1:0] i_prev,
    output logic [rrpd_pkg::COUNT_W-1:0] o_count
);

    logic [rrpd_pkg::COUNT_W-1:0] r_count;
    logic [rrpd_pkg::COUNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_ctl.shift) begin
            // a new run starts with an empty history
            n_count = i_ctl.clear ? '0 : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ----- hdl/rrpd_trigger.sv -----
// ----------------------------------------------------------------------------
// rrpd_trigger
// Running window sums, bin position, hold-off logic and the step compare.
// Decides within the cycle of a bin word whether that word raises a pulse.
// ----------------------------------------------------------------------------
module rrpd_trigger #(
    parameter int WINDOW_BEHIND = rrpd_pkg::WINDOW_BEHIND_DEF,
    parameter int LOOKAHEAD     = rrpd_pkg::LOOKAHEAD_DEF,
    parameter int MAX_BINS      = rrpd_pkg::MAX_BINS_DEF,
    parameter int POS_W         = $clog2(MAX_BINS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_start,
    input  logic [rrpd_pkg::COUNT_W-1:0] i_count,
    input  logic [rrpd_pkg::COUNT_W-1:0] i_tap_ahead,
    input  logic [rrpd_pkg::COUNT_W-1:0] i_tap_behind,
    input  logic [rrpd_pkg::PROM_W-1:0]  i_prominence,
    input  logic [rrpd_pkg::HOLD_W-1:0]  i_holdoff,
    output rrpd_pkg::t_cell_ctl          o_cell_ctl,
    output logic                         o_pulse,
    output logic [POS_W-1:0]             o_pulse_bin
);

    localparam int  CNT_MAX = (1 << rrpd_pkg::COUNT_W) - 1;
    localparam int  CNT_W   = $clog2(MAX_BINS + 1);
    localparam int  SB_W    = $clog2(WINDOW_BEHIND * CNT_MAX + 1);
    localparam int  SA_W    = $clog2(LOOKAHEAD * CNT_MAX + 1);
    localparam int  CMP_W   = $clog2(2 * LOOKAHEAD * WINDOW_BEHIND * CNT_MAX + 1);

    localparam logic [CMP_W-1:0] K_WB   = CMP_W'(WINDOW_BEHIND);
    localparam logic [CMP_W-1:0] K_LA   = CMP_W'(LOOKAHEAD);
    localparam logic [CMP_W-1:0] K_PROM = CMP_W'(LOOKAHEAD * WINDOW_BEHIND);
    localparam logic [CNT_W-1:0] K_MAX  = CNT_W'(MAX_BINS);
    localparam logic [CNT_W-1:0] K_LEAD = CNT_W'(LOOKAHEAD - 1);
    localparam logic [POS_W-1:0] K_WIN  = POS_W'(WINDOW_BEHIND);

    logic [CNT_W-1:0]            r_pos,    n_pos;
    logic [SB_W-1:0]             r_sb,     n_sb;
    logic [SA_W-1:0]             r_sa,     n_sa;
    logic [rrpd_pkg::TICK_W-1:0] r_ticks,  n_ticks;
    logic                        r_recent, n_recent;

    logic [CNT_W-1:0]             base_pos;
    logic [SB_W-1:0]              base_sb;
    logic [SA_W-1:0]              base_sa;
    logic [rrpd_pkg::TICK_W-1:0]  base_ticks;
    logic                         base_recent;
    logic [rrpd_pkg::COUNT_W-1:0] tap_a;
    logic [rrpd_pkg::COUNT_W-1:0] tap_b;
    logic                         active;
    logic                         checked;
    logic [CNT_W-1:0]             p_full;
    logic [POS_W-1:0]             p;
    logic [rrpd_pkg::TICK_W-1:0]  ticks_inc;
    logic                         recent_inc;
    logic                         eligible;
    logic [CMP_W-1:0]             lhs;
    logic [CMP_W-1:0]             rhs;
    logic                         pulse;

    always_comb begin
        // start of run: treat all history as cleared
        base_pos    = i_start ? '0 : r_pos;
        base_sb     = i_start ? '0 : r_sb;
        base_sa     = i_start ? '0 : r_sa;
        base_ticks  = i_start ? '0 : r_ticks;
        base_recent = i_start ? 1'b0 : r_recent;
        tap_a       = i_start ? '0 : i_tap_ahead;
        tap_b       = i_start ? '0 : i_tap_behind;

        active  = base_pos < K_MAX;
        checked = base_pos >= K_LEAD;
        p_full  = base_pos - K_LEAD;
        p       = p_full[POS_W-1:0];

        n_sb = base_sb + SB_W'(tap_a) - SB_W'(tap_b);
        n_sa = base_sa + SA_W'(i_count) - SA_W'(tap_a);

        ticks_inc  = (base_ticks < rrpd_pkg::TICK_MAX) ? base_ticks + 1'b1 : base_ticks;
        recent_inc = (ticks_inc > rrpd_pkg::TICK_W'(i_holdoff)) ? 1'b0 : base_recent;
        eligible   = !recent_inc && (ticks_inc >= rrpd_pkg::TICK_W'(i_holdoff)) && (p > K_WIN);

        lhs   = K_WB * CMP_W'(n_sa);
        rhs   = K_LA * CMP_W'(n_sb) + K_PROM * CMP_W'(i_prominence);
        pulse = i_accept && active && checked && eligible && (lhs > rhs);

        n_pos    = r_pos;
        n_ticks  = r_ticks;
        n_recent = r_recent;
        if (i_accept && active) begin
            n_pos = base_pos + 1'b1;
            if (checked) begin
                n_ticks  = pulse ? '0 : ticks_inc;
                n_recent = pulse | recent_inc;
            end else begin
                n_ticks  = base_ticks;
                n_recent = base_recent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sb     <= '0;
            r_sa     <= '0;
            r_ticks  <= '0;
            r_recent <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_ticks  <= n_ticks;
            r_recent <= n_recent;
            if (i_accept && active) begin
                r_sb <= n_sb;
                r_sa <= n_sa;
            end
        end
    end

    assign o_cell_ctl.shift = i_accept && active;
    assign o_cell_ctl.clear = i_accept && i_start;
    assign o_pulse          = pulse;
    assign o_pulse_bin      = p;

`ifndef SYNTHESIS
    a_pulse_arms_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pulse |=> (r_recent && r_ticks == '0))
        else $error("pulse did not arm hold-off");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= K_MAX)
        else $error("bin position beyond run limit");

    a_pulse_past_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pulse |-> (p > K_WIN && o_cell_ctl.shift))
        else $error("pulse inside behind window or without shift");
`endif

endmodule

// ----- bench/rise_pulse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rise_pulse_checker
// Watches the bin, configuration and pulse channels of the rate rise pulse
// detector. It keeps its own copy of the bin history, running sums and
// hold-off state, predicts the pulse position for every bin word taken, and
// compares each pulse word taken against the oldest predicted position.
// ----------------------------------------------------------------------------
module rise_pulse_checker #(
    parameter int WINDOW_BEHIND = rrpd_pkg::WINDOW_BEHIND_DEF,
    parameter int LOOKAHEAD     = rrpd_pkg::LOOKAHEAD_DEF,
    parameter int MAX_BINS      = rrpd_pkg::MAX_BINS_DEF,
    parameter int POS_W         = $clog2(rrpd_pkg::MAX_BINS_DEF)
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rrpd_bin_if   i_bin_mon,
    rrpd_cfg_if   i_cfg_mon,
    rrpd_pulse_if i_pulse_mon,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_pulse_count
);

    localparam int DEPTH      = WINDOW_BEHIND + LOOKAHEAD;
    localparam int REPORT_MAX = 10;

    // hist[0] is the newest bin
    logic [rrpd_pkg::COUNT_W-1:0] hist [DEPTH];
    logic [20:0]                  sum_back;
    logic [17:0]                  sum_fwd;
    int unsigned                  bins_seen;
    logic [rrpd_pkg::TICK_W-1:0]  ticks;
    bit                           held;
    logic [rrpd_pkg::PROM_W-1:0]  prom_q;
    logic [rrpd_pkg::HOLD_W-1:0]  hold_q;

    logic [POS_W-1:0]   expected_pulse_bins [$];
    int                 failures;
    int                 pulses_taken;

    function automatic void clear_run();
        for (int k = 0; k < DEPTH; k++) hist[k] = '0;
        sum_back  = '0;
        sum_fwd   = '0;
        bins_seen = 0;
        ticks     = '0;
        held      = 1'b0;
    endfunction

    // Slide the windows by one bin and tell whether this bin completes a rise.
    function automatic bit predict_pulse(input logic [rrpd_pkg::COUNT_W-1:0] cnt,
                                         input bit start,
                                         output logic [POS_W-1:0] pos);
        int unsigned     n;
        longint unsigned lhs;
        longint unsigned rhs;
        pos = '0;
        if (start) clear_run();
        // past the end of a run: drop the bin untouched
        if (bins_seen >= MAX_BINS) return 1'b0;
        n = bins_seen;
        bins_seen++;
        sum_back = sum_back + hist[LOOKAHEAD-1] - hist[DEPTH-1];
        sum_fwd  = sum_fwd + cnt - hist[LOOKAHEAD-1];
        for (int k = DEPTH - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = cnt;
        if (n < LOOKAHEAD - 1) return 1'b0;
        if (ticks != rrpd_pkg::TICK_MAX) ticks++;
        if (ticks > hold_q) held = 1'b0;
        if (held || ticks < hold_q) return 1'b0;
        if (n - (LOOKAHEAD - 1) <= WINDOW_BEHIND) return 1'b0;
        lhs = longint'(WINDOW_BEHIND) * sum_fwd;
        rhs = longint'(LOOKAHEAD) * sum_back
            + longint'(LOOKAHEAD) * longint'(WINDOW_BEHIND) * prom_q;
        if (lhs <= rhs) return 1'b0;
        held  = 1'b1;
        ticks = '0;
        pos   = POS_W'(n - (LOOKAHEAD - 1));
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] want;
        if (!i_rst_n) begin
            clear_run();
            prom_q = rrpd_pkg::PROM_RST;
            hold_q = rrpd_pkg::HOLD_RST;
            expected_pulse_bins.delete();
        end else begin
            if (i_pulse_mon.valid && i_pulse_mon.ready) begin
                pulses_taken++;
                if (expected_pulse_bins.size() == 0) begin
                    if (failures < REPORT_MAX)
                        $display("pulse word at bin %0d with none expected",
                                 i_pulse_mon.pulse_bin);
                    failures++;
                end else begin
                    want = expected_pulse_bins.pop_front();
                    if (want !== i_pulse_mon.pulse_bin) begin
                        if (failures < REPORT_MAX)
                            $display("pulse_bin mismatch: expected %0d, got %0d",
                                     want, i_pulse_mon.pulse_bin);
                        failures++;
                    end
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (rrpd_pkg::t_cfg_reg'(i_cfg_mon.index))
                    rrpd_pkg::CFG_PROMINENCE:
                        prom_q = i_cfg_mon.data[rrpd_pkg::PROM_W-1:0];
                    rrpd_pkg::CFG_HOLDOFF:
                        hold_q = i_cfg_mon.data[rrpd_pkg::HOLD_W-1:0];
                endcase
            end
            if (i_bin_mon.valid && i_bin_mon.ready) begin
                if (predict_pulse(i_bin_mon.bin_count, i_bin_mon.start_run, pos))
                    expected_pulse_bins = {expected_pulse_bins, pos};
            end
        end
        o_pending     <= expected_pulse_bins.size();
        o_fail_count  <= failures;
        o_pulse_count <= pulses_taken;
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bin words and register writes into the rate rise pulse detector and
// takes its pulse words: default-setting runs, a short directed run, random
// runs of baselines with bursts over many register settings, and a long
// receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  POS_W          = $clog2(rrpd_pkg::MAX_BINS_DEF);
    localparam int  RANDOM_ITEMS   = 220;
    localparam int  SWAP_ITEMS     = 80;
    localparam int  NO_IDLE_ITEMS  = 150;
    localparam int  RX_HOLD_CYCLES = 400;
    localparam int  DRAIN_CYCLES   = 8;
    localparam int  CYCLE_LIMIT    = 200000;

    logic clk;
    logic rst_n;

    rrpd_bin_if   bin_ch ();
    rrpd_cfg_if   cfg_ch ();
    rrpd_pulse_if pulse_ch ();

    int fail_count;
    int pulses_pending;
    int pulse_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int random_items;
    int cycle_count;
    bit pressure_req;
    logic rx_hold;

    rate_rise_pulse_detector dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_bin   (bin_ch),
        .i_cfg   (cfg_ch),
        .o_pulse (pulse_ch)
    );

    rise_pulse_checker #(
        .POS_W (POS_W)
    ) u_rise_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_bin_mon     (bin_ch),
        .i_cfg_mon     (cfg_ch),
        .i_pulse_mon   (pulse_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pulses_pending),
        .o_pulse_count (pulse_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // pulse receiver
    initial begin
        pulse_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n)
                pulse_ch.ready <= 1'b0;
            else
                pulse_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // long receiver stall, once
    initial begin
        rx_hold = 1'b0;
        wait (pressure_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_bin(input logic [rrpd_pkg::COUNT_W-1:0] cnt, input logic start);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            bin_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bin_ch.valid     <= 1'b1;
        bin_ch.bin_count <= cnt;
        bin_ch.start_run <= start;
        do @(posedge clk); while (!bin_ch.ready);
    endtask

    task automatic write_reg(input rrpd_pkg::t_cfg_reg idx,
                             input logic [rrpd_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every predicted pulse is out and the block is quiet.
    task automatic settle();
        bin_ch.valid <= 1'b0;
        @(posedge clk);
        while (pulses_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One run: a baseline with spread, short bursts, rare noise and rare restarts.
    task automatic send_random_run(input int len);
        int                           base;
        int                           spread;
        int                           burst_left;
        int                           r;
        int                           level;
        logic [rrpd_pkg::COUNT_W-1:0] burst_lvl;
        logic [rrpd_pkg::COUNT_W-1:0] cnt;
        case ($urandom_range(0, 3))
            0:       base = 0;
            1:       base = $urandom_range(0, 200);
            2:       base = $urandom_range(0, 65535);
            default: base = 65535;
        endcase
        spread     = $urandom_range(0, 1) ? $urandom_range(0, 50) : $urandom_range(0, 4000);
        burst_left = 0;
        burst_lvl  = '0;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (burst_left == 0 && r < 8) begin
                burst_left = $urandom_range(1, 6);
                burst_lvl  = rrpd_pkg::COUNT_W'($urandom_range(base, 65535));
            end
            if (r >= 97) begin
                cnt = rrpd_pkg::COUNT_W'($urandom);
            end else if (burst_left > 0) begin
                cnt = burst_lvl;
                burst_left--;
            end else begin
                level = base + $urandom_range(0, spread);
                cnt   = (level > 65535) ? 16'hFFFF : rrpd_pkg::COUNT_W'(level);
            end
            send_bin(cnt, (i == 0) || (r == 50));
            random_items++;
        end
    endtask

    initial begin
        int phase;
        rst_n            = 1'b0;
        bin_ch.valid     = 1'b0;
        bin_ch.bin_count = '0;
        bin_ch.start_run = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = rrpd_pkg::CFG_PROMINENCE;
        cfg_ch.data      = '0;
        pressure_req     = 1'b0;
        tx_idle_pct      = 16;
        rx_idle_pct      = 50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings; the very first bin does not restart the run
        send_bin('0, 1'b0);
        send_random_run(90);
        send_random_run(90);

        // zero prominence and zero hold-off; upper hold-off bits are dropped
        settle();
        write_reg(rrpd_pkg::CFG_PROMINENCE, 16'h0000);
        write_reg(rrpd_pkg::CFG_HOLDOFF, 16'hFC00);
        send_bin(16'hFFFF, 1'b1);
        repeat (33) send_bin('0, 1'b0);
        repeat (4) send_bin(16'hFFFF, 1'b0);
        repeat (2) send_bin('0, 1'b0);
        send_bin(16'd1234, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin('0, 1'b0);

        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= NO_IDLE_ITEMS) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (random_items >= SWAP_ITEMS) begin
                tx_idle_pct = 50;
                rx_idle_pct = 16;
            end
            settle();
            case (phase % 6)
                0: begin
                    write_reg(rrpd_pkg::CFG_PROMINENCE, 16'h0000);
                    write_reg(rrpd_pkg::CFG_HOLDOFF, 16'd1);
                end
                1: begin
                    write_reg(rrpd_pkg::CFG_PROMINENCE, 16'hFFFF);
                    write_reg(rrpd_pkg::CFG_HOLDOFF, 16'hFFFF);
                end
                2: begin
                    write_reg(rrpd_pkg::CFG_PROMINENCE, 16'($urandom_range(0, 2000)));
                    write_reg(rrpd_pkg::CFG_HOLDOFF,
                              {6'($urandom), 10'($urandom_range(0, 8))});
                end
                3: begin
                    write_reg(rrpd_pkg::CFG_PROMINENCE, 16'($urandom));
                    write_reg(rrpd_pkg::CFG_HOLDOFF, 16'($urandom));
                end
                4: begin
                    write_reg(rrpd_pkg::CFG_PROMINENCE, 16'(rrpd_pkg::PROM_RST));
                    write_reg(rrpd_pkg::CFG_HOLDOFF, 16'(rrpd_pkg::HOLD_RST));
                end
                default: begin
                    write_reg(rrpd_pkg::CFG_PROMINENCE, 16'($urandom_range(0, 300)));
                    write_reg(rrpd_pkg::CFG_HOLDOFF, 16'($urandom_range(1, 40)));
                end
            endcase
            phase++;
            repeat ($urandom_range(1, 2)) send_random_run($urandom_range(36, 110));
        end

        // back the block up: steep steps give a pulse per bin while the receiver holds
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        settle();
        write_reg(rrpd_pkg::CFG_PROMINENCE, 16'h0000);
        write_reg(rrpd_pkg::CFG_HOLDOFF, 16'h0000);
        pressure_req = 1'b1;
        send_bin('0, 1'b1);
        repeat (33) send_bin('0, 1'b0);
        repeat (40) send_bin(16'hFFFF, 1'b0);

        settle();
        if (fail_count == 0 && pulses_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
